// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, constants and result lookup for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int LINE_LIMIT = 127;
   localparam int LEN_W      = $clog2(LINE_LIMIT + 1);
   localparam int IDX_W      = 3;

   // terminal bytes
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam logic [1:0] ESC_SKIP_LEN = 2'd3;

   // result action codes
   localparam logic [1:0] ACT_ECHO   = 2'd0;
   localparam logic [1:0] ACT_STORE  = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // kind of result sequence one byte produces
   typedef enum logic [2:0] {
      SEQ_ERASE  = 3'b001,
      SEQ_PROMPT = 3'b010,
      SEQ_CHAR   = 3'b100
   } seq_type;

   typedef struct packed {
      logic             has_job;
      seq_type          kind;
      logic [IDX_W-1:0] cnt;
      logic [7:0]       data;
      logic [1:0]       escape_skip;
      logic [LEN_W-1:0] line_length;
   } dec_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data;
   } res_type;

   function automatic res_type result_at(seq_type kind, logic [IDX_W-1:0] idx,
                                         logic [7:0] data);
      res_type r;
      r.action = ACT_ECHO;
      r.data   = CH_NUL;
      case (kind)
         SEQ_ERASE: begin
            case (idx)
               3'd0: begin
                  r.action = ACT_REMOVE;
                  r.data   = CH_NUL;
               end
               3'd2:    r.data = CH_SP;
               default: r.data = CH_BS;
            endcase
         end
         SEQ_PROMPT: begin
            case (idx)
               3'd0:    r.data = CH_CR;
               3'd1:    r.data = CH_LF;
               3'd2:    r.data = CH_GT;
               3'd3:    r.data = CH_SP;
               3'd5:    r.action = ACT_STORE;
               default: r.data = CH_NUL;
            endcase
         end
         SEQ_CHAR: begin
            r.data = data;
            if (idx == 3'd0) begin
               r.action = ACT_STORE;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor
// Terminal line editor with echo: one received byte in, line-store commands
// and echo bytes out.
// ----------------------------------------------------------------------------
// Each accepted byte produces zero to six results, delivered one per cycle
// from a result register while the result side is ready; the last of them
// carries rsp_last. A byte that produces results holds the block until its
// last result has moved into the single result register; the next byte is
// taken in the same cycle as the previous byte's last result moves into the
// result register, so results stream with no gaps while the result side is
// ready. Escape sequences (escape plus three bytes) and bytes beyond a full
// line produce no results.
module console_line_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);
   import cle_pkg::*;

   logic [1:0]       escape_skip_ff, escape_skip_in;
   logic [LEN_W-1:0] line_length_ff, line_length_in;

   logic             job_valid_ff, job_valid_in;
   seq_type          job_kind_ff, job_kind_in;
   logic [IDX_W-1:0] job_cnt_ff, job_cnt_in;
   logic [IDX_W-1:0] job_idx_ff, job_idx_in;
   logic [7:0]       job_data_ff, job_data_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_action_ff, rsp_action_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   dec_type dec;
   res_type res;
   logic    out_load;
   logic    job_final;
   logic    job_done;
   logic    req_take;

   cle_decode u_decode (
      .rx_byte     (req_rx_byte),
      .escape_skip (escape_skip_ff),
      .line_length (line_length_ff),
      .dec         (dec)
   );

   assign res       = result_at(job_kind_ff, job_idx_ff, job_data_ff);
   assign out_load  = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign job_final = (job_idx_ff == job_cnt_ff - 3'd1);
   assign job_done  = out_load && job_final;
   assign req_ready = !job_valid_ff || job_done;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      escape_skip_in = escape_skip_ff;
      line_length_in = line_length_ff;
      job_valid_in   = job_valid_ff;
      job_kind_in    = job_kind_ff;
      job_cnt_in     = job_cnt_ff;
      job_idx_in     = job_idx_ff;
      job_data_in    = job_data_ff;

      if (out_load) begin
         job_idx_in = job_idx_ff + 3'd1;
      end
      if (job_done) begin
         job_valid_in = 1'b0;
      end
      if (req_take) begin
         escape_skip_in = dec.escape_skip;
         line_length_in = dec.line_length;
         if (dec.has_job) begin
            job_valid_in = 1'b1;
            job_kind_in  = dec.kind;
            job_cnt_in   = dec.cnt;
            job_idx_in   = '0;
            job_data_in  = dec.data;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_action_in = rsp_action_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = res.action;
         rsp_data_in   = res.data;
         rsp_last_in   = job_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_skip_ff <= '0;
         line_length_ff <= '0;
         job_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         escape_skip_ff <= escape_skip_in;
         line_length_ff <= line_length_in;
         job_valid_ff   <= job_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_kind_ff   <= job_kind_in;
      job_cnt_ff    <= job_cnt_in;
      job_idx_ff    <= job_idx_in;
      job_data_ff   <= job_data_in;
      rsp_action_ff <= rsp_action_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/cle_decode.sv =====
// ----------------------------------------------------------------------------
// cle_decode
// Classifies one received byte against the editor state and gives the
// result sequence it starts along with the next escape and length state.
// ----------------------------------------------------------------------------
module cle_decode (
   input  logic [7:0]                rx_byte,
   input  logic [1:0]                escape_skip,
   input  logic [cle_pkg::LEN_W-1:0] line_length,
   output cle_pkg::dec_type          dec
);
   import cle_pkg::*;

   logic line_empty;
   logic line_end;

   assign line_empty = (line_length == '0);
   assign line_end   = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_NUL);

   always_comb begin
      dec             = '0;
      dec.kind        = SEQ_CHAR;
      dec.data        = rx_byte;
      dec.escape_skip = escape_skip;
      dec.line_length = line_length;
      if (rx_byte == CH_ESC) begin
         dec.escape_skip = ESC_SKIP_LEN;
      end else if (escape_skip != 2'd0) begin
         dec.escape_skip = escape_skip - 2'd1;
      end else if (rx_byte == CH_BS) begin
         if (!line_empty) begin
            dec.has_job     = 1'b1;
            dec.kind        = SEQ_ERASE;
            dec.cnt         = 3'd4;
            dec.line_length = line_length - LEN_W'(1);
         end
      end else if (line_end) begin
         dec.has_job     = 1'b1;
         dec.kind        = SEQ_PROMPT;
         // non-empty line also gets a stored terminator
         dec.cnt         = line_empty ? 3'd5 : 3'd6;
         dec.line_length = '0;
      end else if (line_length < LEN_W'(LINE_LIMIT)) begin
         dec.has_job     = 1'b1;
         dec.kind        = SEQ_CHAR;
         dec.cnt         = 3'd2;
         dec.line_length = line_length + LEN_W'(1);
      end
   end

endmodule

// ===== rtl/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_action,
   input logic [7:0] rsp_data,
   input logic       rsp_last
);
   import cle_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_data)
         && $stable(rsp_last))
      else $error("result changed while stalled");

   // remove carries zero and is never the final result
   a_remove_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_REMOVE |-> rsp_data == CH_NUL && !rsp_last)
      else $error("bad remove result");

   // remove is followed at once by the backspace echo
   a_remove_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_action == ACT_REMOVE
      |=> rsp_valid && rsp_action == ACT_ECHO && rsp_data == CH_BS)
      else $error("remove not followed by backspace echo");

   // a stored ordinary byte is echoed next
   a_store_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_action == ACT_STORE && !rsp_last
      |=> rsp_valid && rsp_action == ACT_ECHO && rsp_data == $past(rsp_data) && rsp_last)
      else $error("stored byte not echoed");

   // no undefined action code
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action == ACT_ECHO || rsp_action == ACT_STORE
         || rsp_action == ACT_REMOVE)
      else $error("undefined action code");

endmodule

bind console_line_editor cle_checker u_cle_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_action  (rsp_action),
   .rsp_data    (rsp_data),
   .rsp_last    (rsp_last)
);

// ===== test/console_line_editor_test.sv =====
// ----------------------------------------------------------------------------
// console_line_editor_test
// Drives terminal bytes into the line editor and checks every store, remove
// and echo result against an in-bench line editing model, with random idling
// on both sides, a long result stall and drain pauses on the byte side.
// ----------------------------------------------------------------------------
module console_line_editor_test;

   import cle_pkg::*;

   localparam int TAIL_ITEMS = 30;

   typedef struct {
      logic [1:0] action;
      logic [7:0] data;
      logic       last;
   } line_cmd_type;

   typedef struct {
      logic [7:0] rx;
      bit         hold;
   } rx_item_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_action;
   logic [7:0] rsp_data;
   logic       rsp_last;

   console_line_editor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   always #5 clock = ~clock;

   rx_item_type  rx_q[$];
   line_cmd_type cmd_q[$];
   bit           hold_next;

   // editor state as seen from outside
   logic [1:0]       esc_left = '0;
   logic [LEN_W-1:0] line_len = '0;

   int n_offered, n_taken, n_results, n_errors;
   int n_escapes, n_erases, n_prompts, n_full_drops, longest_line;
   int send_gap, recv_gap, recv_stall;
   bit stall_done;

   // no idling in the tail of the run, nor in every third block of 32 items
   function automatic bit may_idle();
      return rx_q.size() > TAIL_ITEMS && (n_taken / 32) % 3 != 2;
   endfunction

   task automatic edit_line(input logic [7:0] b);
      line_cmd_type seq[$];
      if (b == CH_ESC) begin
         esc_left = ESC_SKIP_LEN;
         n_escapes++;
         return;
      end
      if (esc_left != 0) begin
         esc_left--;
         return;
      end
      if (b == CH_BS) begin
         if (line_len != 0) begin
            seq.push_back('{ACT_REMOVE, CH_NUL, 1'b0});
            seq.push_back('{ACT_ECHO, CH_BS, 1'b0});
            seq.push_back('{ACT_ECHO, CH_SP, 1'b0});
            seq.push_back('{ACT_ECHO, CH_BS, 1'b0});
            line_len--;
            n_erases++;
         end
      end else if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
         seq.push_back('{ACT_ECHO, CH_CR, 1'b0});
         seq.push_back('{ACT_ECHO, CH_LF, 1'b0});
         seq.push_back('{ACT_ECHO, CH_GT, 1'b0});
         seq.push_back('{ACT_ECHO, CH_SP, 1'b0});
         seq.push_back('{ACT_ECHO, CH_NUL, 1'b0});
         if (line_len != 0) begin
            seq.push_back('{ACT_STORE, CH_NUL, 1'b0});
            line_len = '0;
         end
         n_prompts++;
      end else if (line_len < LINE_LIMIT) begin
         seq.push_back('{ACT_STORE, b, 1'b0});
         seq.push_back('{ACT_ECHO, b, 1'b0});
         line_len++;
         if (line_len > longest_line) longest_line = line_len;
      end else begin
         n_full_drops++;
      end
      if (seq.size() > 0) seq[seq.size() - 1].last = 1'b1;
      foreach (seq[i]) cmd_q.push_back(seq[i]);
   endtask

   // result check first: a result at the edge an item is taken is an older one
   always @(posedge clock) begin : check_results
      line_cmd_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (cmd_q.size() == 0) begin
               $error("unexpected result: action %0d data %02h last %0b",
                      rsp_action, rsp_data, rsp_last);
               n_errors++;
            end else begin
               want = cmd_q.pop_front();
               if (rsp_action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, rsp_action);
                  n_errors++;
               end
               if (rsp_data !== want.data) begin
                  $error("data: expected %02h, got %02h", want.data, rsp_data);
                  n_errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  n_errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            edit_line(req_rx_byte);
            n_taken++;
         end
      end
   end

   always @(negedge clock) begin : drive_bytes
      logic       next_valid;
      logic [7:0] next_byte;
      next_valid = req_valid;
      next_byte  = req_rx_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else if (n_taken == n_offered) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (rx_q.size() > 0 && !(rx_q[0].hold && cmd_q.size() != 0)) begin
            next_byte  = rx_q[0].rx;
            next_valid = 1'b1;
            void'(rx_q.pop_front());
            n_offered++;
            if (may_idle() && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 16);
         end
      end
      req_valid   <= next_valid;
      req_rx_byte <= next_byte;
   end

   always @(negedge clock) begin : accept_results
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (!stall_done && n_taken >= 40) begin
         // long hold-off while bytes keep coming, backs up into req_ready
         stall_done = 1;
         recv_stall = 250;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_rx(input logic [7:0] b);
      rx_q.push_back('{b, hold_next});
      hold_next = 0;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = CH_ESC;
      while (b == CH_ESC || b == CH_BS || b == CH_CR || b == CH_LF || b == CH_NUL)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] line_end();
      case ($urandom_range(0, 2))
         0:       return CH_CR;
         1:       return CH_LF;
         default: return CH_NUL;
      endcase
   endfunction

   initial begin
      int counted, n, seg;
      bit long_done;

      // directed: plain bytes, erase on non-empty and empty line, all line ends,
      // byte extremes, escape skip with specials inside, escape restart
      push_rx(8'h61);
      push_rx(CH_BS);
      push_rx(CH_BS);
      push_rx(CH_CR);
      push_rx(8'hFF);
      push_rx(8'h80);
      push_rx(8'h01);
      push_rx(8'h7F);
      push_rx(CH_LF);
      push_rx(8'h78);
      push_rx(CH_NUL);
      push_rx(CH_ESC);
      push_rx(8'h41);
      push_rx(8'h42);
      push_rx(8'h43);
      push_rx(CH_ESC);
      push_rx(CH_CR);
      push_rx(CH_ESC);
      push_rx(CH_BS);
      push_rx(CH_NUL);
      push_rx(8'hFE);
      push_rx(8'h71);
      push_rx(CH_CR);
      push_rx(CH_LF);

      hold_next = 1;
      counted   = rx_q.size();
      long_done = 0;
      while (counted < 260) begin
         if ($urandom_range(0, 24) == 0) hold_next = 1;
         seg = $urandom_range(0, 99);
         if (!long_done && counted >= 60) begin
            // fill the line past its limit, trim, refill and overflow again
            long_done = 1;
            n = LINE_LIMIT + $urandom_range(1, 6);
            repeat (n) push_rx(plain_byte());
            repeat (2) push_rx(CH_BS);
            repeat (4) push_rx(plain_byte());
            push_rx(CH_CR);
            counted += n + 7;
         end else if (seg < 55) begin
            n = $urandom_range(0, 20);
            repeat (n) push_rx($urandom_range(0, 4) == 0 ? CH_BS : plain_byte());
            push_rx(line_end());
            counted += n + 1;
         end else if (seg < 70) begin
            push_rx(CH_ESC);
            counted++;
            n = 3;
            while (n > 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  push_rx(CH_ESC);
                  n = 3;
               end else begin
                  push_rx($urandom_range(0, 3) == 0 ? line_end()
                                                    : 8'($urandom_range(0, 255)));
                  n--;
               end
               counted++;
            end
         end else if (seg < 85) begin
            n = $urandom_range(1, 6);
            repeat (n) push_rx(8'($urandom_range(0, 255)));
            counted += n;
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_rx(CH_BS);
            push_rx(line_end());
            counted += n + 1;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (rx_q.size() != 0 || n_taken != n_offered) @(posedge clock);
      while (cmd_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("covered %0d bytes and %0d results: %0d escapes, %0d erases, %0d line ends",
               n_taken, n_results, n_escapes, n_erases, n_prompts);
      $display("longest line %0d bytes, %0d bytes dropped on a full line",
               longest_line, n_full_drops);
      if (n_errors == 0 && cmd_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
